/* hdl/isc_pkg.sv */
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, constants and the microcode program of the inactivity
// sleep and stopwatch controller.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam int ISC_WINDOW_DEPTH = 30;

    // Field widths
    localparam int X_W      = 13;
    localparam int CLK_W    = 6;
    localparam int EV_W     = 3;
    localparam int HOURS_W  = 5;
    localparam int ELAPSED_W = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int PC_W     = 5;

    // Register reset values
    localparam logic signed [X_W-1:0] ISC_TILT_RESET = -13'sd800;
    localparam logic [X_W-1:0]        ISC_TOL_RESET  = 13'd50;
    localparam logic signed [X_W-1:0] ISC_WIN_INIT   = -13'sd100;

    // Register indexes (paddr[2])
    localparam logic REG_TILT = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    // Input action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_TAP     = 2'd1;
    localparam logic [1:0] ACT_BATCH   = 2'd2;
    localparam logic [1:0] ACT_REFRESH = 2'd3;

    // Result event codes
    localparam logic [EV_W-1:0] EV_IGNORED   = 3'd0;
    localparam logic [EV_W-1:0] EV_REFRESHED = 3'd1;
    localparam logic [EV_W-1:0] EV_SLEPT     = 3'd2;
    localparam logic [EV_W-1:0] EV_WOKE      = 3'd3;
    localparam logic [EV_W-1:0] EV_ARMED     = 3'd4;
    localparam logic [EV_W-1:0] EV_SW_ON     = 3'd5;
    localparam logic [EV_W-1:0] EV_SW_OFF    = 3'd6;
    localparam logic [EV_W-1:0] EV_NONE      = 3'd7;

    // Reciprocal split of the elapsed counter: q = (v * RECIP) >> SHIFT
    localparam logic [31:0] ISC_HOUR_RECIP   = 32'd37283;
    localparam int          ISC_HOUR_SHIFT   = 27;
    localparam logic [31:0] ISC_SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] ISC_MIN_RECIP    = 32'd4370;
    localparam int          ISC_MIN_SHIFT    = 18;
    localparam logic [31:0] ISC_SEC_PER_MIN  = 32'd60;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_POST_IGN,
        OP_CLR_PEND,
        OP_WIN_WR,
        OP_SCAN_ISSUE,
        OP_SCAN_ACC,
        OP_POST_SLEPT,
        OP_MUL_H,
        OP_HOURS,
        OP_MUL_HM,
        OP_REM,
        OP_MUL_M,
        OP_MINUTES,
        OP_MUL_MS,
        OP_SECONDS,
        OP_POST_RUN,
        OP_POST_STOP,
        OP_OTHER
    } op_t;

    typedef enum logic [3:0] {
        J_NEXT,
        J_ALWAYS,
        J_WAIT,
        J_NOT_TICK,
        J_TICK_LIVE,
        J_SEC_NZ,
        J_SCAN_MORE,
        J_NOT_STILL,
        J_SW_OFF
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic en;
    } ctrl_t;

    typedef struct packed {
        logic is_tick;
        logic tick_live;
        logic sec_nz;
        logic scan_more;
        logic still;
        logic sw_on;
        logic out_busy;
    } stat_t;

    // Program entry points
    localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] PC_LIVE  = 5'd4;
    localparam logic [PC_W-1:0] PC_SCAN  = 5'd7;
    localparam logic [PC_W-1:0] PC_TIME  = 5'd10;
    localparam logic [PC_W-1:0] PC_STOP  = 5'd19;
    localparam logic [PC_W-1:0] PC_OTHER = 5'd20;

    function automatic uword_t isc_ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = '{OP_LATCH,      J_WAIT,      PC_IDLE};
            5'd1:    w = '{OP_NOP,        J_NOT_TICK,  PC_OTHER};
            5'd2:    w = '{OP_NOP,        J_TICK_LIVE, PC_LIVE};
            5'd3:    w = '{OP_POST_IGN,   J_ALWAYS,    PC_IDLE};
            5'd4:    w = '{OP_CLR_PEND,   J_SEC_NZ,    PC_TIME};
            5'd5:    w = '{OP_WIN_WR,     J_NEXT,      PC_IDLE};
            5'd6:    w = '{OP_SCAN_ISSUE, J_NEXT,      PC_IDLE};
            5'd7:    w = '{OP_SCAN_ACC,   J_SCAN_MORE, PC_SCAN};
            5'd8:    w = '{OP_NOP,        J_NOT_STILL, PC_TIME};
            5'd9:    w = '{OP_POST_SLEPT, J_ALWAYS,    PC_IDLE};
            5'd10:   w = '{OP_MUL_H,      J_SW_OFF,    PC_STOP};
            5'd11:   w = '{OP_HOURS,      J_NEXT,      PC_IDLE};
            5'd12:   w = '{OP_MUL_HM,     J_NEXT,      PC_IDLE};
            5'd13:   w = '{OP_REM,        J_NEXT,      PC_IDLE};
            5'd14:   w = '{OP_MUL_M,      J_NEXT,      PC_IDLE};
            5'd15:   w = '{OP_MINUTES,    J_NEXT,      PC_IDLE};
            5'd16:   w = '{OP_MUL_MS,     J_NEXT,      PC_IDLE};
            5'd17:   w = '{OP_SECONDS,    J_NEXT,      PC_IDLE};
            5'd18:   w = '{OP_POST_RUN,   J_ALWAYS,    PC_IDLE};
            5'd19:   w = '{OP_POST_STOP,  J_ALWAYS,    PC_IDLE};
            5'd20:   w = '{OP_OTHER,      J_ALWAYS,    PC_IDLE};
            default: w = '{OP_NOP,        J_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic isc_is_post(input op_t op);
        logic p;
        p = (op == OP_POST_IGN) || (op == OP_POST_SLEPT) || (op == OP_POST_RUN) ||
            (op == OP_POST_STOP) || (op == OP_OTHER);
        return p;
    endfunction

endpackage

/* hdl/isc_ram.sv */
// ----------------------------------------------------------------------------
// isc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module isc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 30
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/isc_seq.sv */
// ----------------------------------------------------------------------------
// isc_seq
// Microcode sequencer: step counter, program table and jump logic.
// ----------------------------------------------------------------------------
module isc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  isc_pkg::stat_t stat,
    output isc_pkg::ctrl_t ctrl
);
    import isc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            in_fire;
    logic            stall;
    logic            take;

    assign uw       = isc_ucode(pc_reg);
    assign s_tready = (uw.op == OP_LATCH);
    assign in_fire  = s_tvalid && s_tready;
    // a result step waits while the output register still holds an untaken result
    assign stall    = isc_is_post(uw.op) && stat.out_busy;

    always_comb
    begin
        case (uw.cond)
            J_NEXT:      take = 1'b0;
            J_ALWAYS:    take = 1'b1;
            J_WAIT:      take = !in_fire;
            J_NOT_TICK:  take = !stat.is_tick;
            J_TICK_LIVE: take = stat.tick_live;
            J_SEC_NZ:    take = stat.sec_nz;
            J_SCAN_MORE: take = stat.scan_more;
            J_NOT_STILL: take = !stat.still;
            J_SW_OFF:    take = !stat.sw_on;
            default:     take = 1'b0;
        endcase

        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end

        ctrl.op = uw.op;
        ctrl.en = (uw.op == OP_LATCH) ? in_fire : !stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/isc_dp.sv */
// ----------------------------------------------------------------------------
// isc_dp
// Datapath: mode flags, motion window with serial min/max scan, elapsed
// counter split by reciprocal multiply, and the output register.
// ----------------------------------------------------------------------------
module isc_dp #(
    parameter int WINDOW_DEPTH = isc_pkg::ISC_WINDOW_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  isc_pkg::ctrl_t                        ctrl,
    output isc_pkg::stat_t                        stat,
    input  logic [isc_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [isc_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [isc_pkg::EV_W-1:0]              m_tuser,
    input  logic signed [isc_pkg::X_W-1:0]        tilt,
    input  logic [isc_pkg::X_W-1:0]               tol
);
    import isc_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int PW = $clog2(WINDOW_DEPTH + 1);

    // latched item
    logic [1:0]              action_reg, action_next;
    logic signed [X_W-1:0]   x_reg, x_next;
    logic [CLK_W-1:0]        sec_reg, sec_next;
    logic [CLK_W-1:0]        minute_reg, minute_next;

    // control state
    logic                    sleep_reg, sleep_next;
    logic                    sw_reg, sw_next;
    logic                    pend_reg, pend_next;
    logic                    armed_reg, armed_next;
    logic [ELAPSED_W-1:0]    elapsed_reg, elapsed_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [PW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    first_reg, first_next;
    logic                    out_valid_reg, out_valid_next;

    // working registers
    logic signed [X_W-1:0]   lo_reg, lo_next;
    logic signed [X_W-1:0]   hi_reg, hi_next;
    logic [31:0]             prod_reg, prod_next;
    logic [HOURS_W-1:0]      hours_reg, hours_next;
    logic [11:0]             rem_reg, rem_next;
    logic [CLK_W-1:0]        mins_reg, mins_next;
    logic [CLK_W-1:0]        secs_reg, secs_next;

    // result register
    logic [EV_W-1:0]         ev_reg, ev_next;
    logic                    run_reg, run_next;
    logic [HOURS_W-1:0]      oh_reg, oh_next;
    logic [CLK_W-1:0]        om_reg, om_next;
    logic [CLK_W-1:0]        os_reg, os_next;
    logic                    wx_reg, wx_next;

    // window RAM
    logic                    ram_we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic [X_W-1:0]          ram_rdata;
    logic [AW-1:0]           rd_addr_q;
    logic                    vld_q;
    logic signed [X_W-1:0]   win_val;
    logic [X_W:0]            spread;
    logic                    scan_more;
    logic                    wx_now;

    assign waddr     = (pos_reg >= PW'(WINDOW_DEPTH)) ? '0 : pos_reg[AW-1:0];
    assign ram_we    = ctrl.en && (ctrl.op == OP_WIN_WR);
    assign raddr     = (ctrl.op == OP_SCAN_ISSUE) ? '0 : scan_idx_reg[AW-1:0];
    assign scan_more = (scan_idx_reg < PW'(WINDOW_DEPTH));
    assign wx_now    = (minute_reg == '0) && (sec_reg == '0);

    isc_ram #(
        .WIDTH (X_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (x_reg),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // never-written entries read as their reset value
    always_comb
    begin
        if (vld_q)
        begin
            win_val = $signed(ram_rdata);
        end
        else if (rd_addr_q == AW'(1))
        begin
            win_val = ISC_WIN_INIT;
        end
        else
        begin
            win_val = '0;
        end
    end

    assign spread = {hi_reg[X_W-1], hi_reg} - {lo_reg[X_W-1], lo_reg};

    assign stat.is_tick   = (action_reg == ACT_TICK);
    assign stat.tick_live = !(sleep_reg || (!pend_reg && !sw_reg && (sec_reg != '0)));
    assign stat.sec_nz    = (sec_reg != '0);
    assign stat.scan_more = scan_more;
    assign stat.still     = (spread < {1'b0, tol});
    assign stat.sw_on     = sw_reg;
    assign stat.out_busy  = out_valid_reg && !m_tready;

    always_comb
    begin
        action_next    = action_reg;
        x_next         = x_reg;
        sec_next       = sec_reg;
        minute_next    = minute_reg;
        sleep_next     = sleep_reg;
        sw_next        = sw_reg;
        pend_next      = pend_reg;
        armed_next     = armed_reg;
        elapsed_next   = elapsed_reg;
        pos_next       = pos_reg;
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        first_next     = first_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        prod_next      = prod_reg;
        hours_next     = hours_reg;
        rem_next       = rem_reg;
        mins_next      = mins_reg;
        secs_next      = secs_reg;
        ev_next        = ev_reg;
        run_next       = run_reg;
        oh_next        = oh_reg;
        om_next        = om_reg;
        os_next        = os_reg;
        wx_next        = wx_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (ctrl.en)
        begin
            case (ctrl.op)
                OP_LATCH:
                begin
                    action_next = s_tuser;
                    x_next      = $signed(s_tdata[X_W-1:0]);
                    sec_next    = s_tdata[X_W +: CLK_W];
                    minute_next = s_tdata[X_W+CLK_W +: CLK_W];
                end
                OP_POST_IGN:
                begin
                    out_valid_next = 1'b1;
                    ev_next  = EV_IGNORED;
                    run_next = sw_reg;
                    oh_next  = '0;
                    om_next  = '0;
                    os_next  = '0;
                    wx_next  = 1'b0;
                end
                OP_CLR_PEND:
                begin
                    pend_next = 1'b0;
                end
                OP_WIN_WR:
                begin
                    pos_next          = PW'(waddr) + 1'b1;
                    valid_next[waddr] = 1'b1;
                end
                OP_SCAN_ISSUE:
                begin
                    scan_idx_next = PW'(1);
                    first_next    = 1'b1;
                end
                OP_SCAN_ACC:
                begin
                    if (first_reg)
                    begin
                        lo_next    = win_val;
                        hi_next    = win_val;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        if (win_val < lo_reg)
                        begin
                            lo_next = win_val;
                        end
                        if (win_val > hi_reg)
                        begin
                            hi_next = win_val;
                        end
                    end
                    if (scan_more)
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                OP_POST_SLEPT:
                begin
                    sleep_next     = 1'b1;
                    out_valid_next = 1'b1;
                    ev_next  = EV_SLEPT;
                    run_next = sw_reg;
                    oh_next  = '0;
                    om_next  = '0;
                    os_next  = '0;
                    wx_next  = 1'b0;
                end
                OP_MUL_H:
                begin
                    prod_next = {16'd0, elapsed_reg} * ISC_HOUR_RECIP;
                end
                OP_HOURS:
                begin
                    hours_next = prod_reg[ISC_HOUR_SHIFT +: HOURS_W];
                end
                OP_MUL_HM:
                begin
                    prod_next = {27'd0, hours_reg} * ISC_SEC_PER_HOUR;
                end
                OP_REM:
                begin
                    rem_next = 12'(elapsed_reg - prod_reg[15:0]);
                end
                OP_MUL_M:
                begin
                    prod_next = {20'd0, rem_reg} * ISC_MIN_RECIP;
                end
                OP_MINUTES:
                begin
                    mins_next = prod_reg[ISC_MIN_SHIFT +: CLK_W];
                end
                OP_MUL_MS:
                begin
                    prod_next = {26'd0, mins_reg} * ISC_SEC_PER_MIN;
                end
                OP_SECONDS:
                begin
                    secs_next = 6'(rem_reg - prod_reg[11:0]);
                end
                OP_POST_RUN:
                begin
                    elapsed_next   = elapsed_reg + 1'b1;
                    out_valid_next = 1'b1;
                    ev_next  = EV_REFRESHED;
                    run_next = sw_reg;
                    oh_next  = hours_reg;
                    om_next  = mins_reg;
                    os_next  = secs_reg;
                    wx_next  = wx_now;
                end
                OP_POST_STOP:
                begin
                    elapsed_next   = '0;
                    out_valid_next = 1'b1;
                    ev_next  = EV_REFRESHED;
                    run_next = sw_reg;
                    oh_next  = '0;
                    om_next  = '0;
                    os_next  = '0;
                    wx_next  = wx_now;
                end
                OP_OTHER:
                begin
                    ev_next = EV_NONE;
                    case (action_reg)
                        ACT_TAP:
                        begin
                            if (sleep_reg)
                            begin
                                sleep_next = 1'b0;
                                pend_next  = 1'b1;
                                ev_next    = EV_WOKE;
                            end
                            else
                            begin
                                armed_next = 1'b1;
                                ev_next    = EV_ARMED;
                            end
                        end
                        ACT_BATCH:
                        begin
                            if (armed_reg)
                            begin
                                armed_next = 1'b0;
                                if (x_reg < tilt)
                                begin
                                    if (sw_reg)
                                    begin
                                        sw_next   = 1'b0;
                                        pend_next = 1'b1;
                                        ev_next   = EV_SW_OFF;
                                    end
                                    else
                                    begin
                                        sw_next = 1'b1;
                                        ev_next = EV_SW_ON;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            pend_next = 1'b1;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    run_next = sw_next;
                    oh_next  = '0;
                    om_next  = '0;
                    os_next  = '0;
                    wx_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_reg     <= 1'b0;
            sw_reg        <= 1'b0;
            pend_reg      <= 1'b1;
            armed_reg     <= 1'b0;
            elapsed_reg   <= '0;
            pos_reg       <= '0;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sleep_reg     <= sleep_next;
            sw_reg        <= sw_next;
            pend_reg      <= pend_next;
            armed_reg     <= armed_next;
            elapsed_reg   <= elapsed_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            scan_idx_reg  <= scan_idx_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        x_reg      <= x_next;
        sec_reg    <= sec_next;
        minute_reg <= minute_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        prod_reg   <= prod_next;
        hours_reg  <= hours_next;
        rem_reg    <= rem_next;
        mins_reg   <= mins_next;
        secs_reg   <= secs_next;
        ev_reg     <= ev_next;
        run_reg    <= run_next;
        oh_reg     <= oh_next;
        om_reg     <= om_next;
        os_reg     <= os_next;
        wx_reg     <= wx_next;
        rd_addr_q  <= raddr;
        vld_q      <= valid_reg[raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ev_reg;
    assign m_tdata  = {5'd0, wx_reg, os_reg, om_reg, oh_reg, run_reg};

endmodule

/* hdl/inactivity_sleep_and_stopwatch_ctrl_core.sv */
// ----------------------------------------------------------------------------
// inactivity_sleep_and_stopwatch_ctrl_core
// Wearable motion controller: inactivity sleep, tap wake, tilt-toggled
// stopwatch, run by a microcoded sequencer over a plain datapath.
// ----------------------------------------------------------------------------
// Tap, batch and refresh items: the idle step latches the item and the tick test jumps to the
// result step; no new item is taken before the result is posted. An ignored tick fails the live
// test; a tick off the minute runs the hours/minutes/seconds split (or the stop result when the
// stopwatch is off). Minute ticks add a serial min/max scan through the RAM's single read port.
// Reset: control state clears at once; the window reads its reset contents through
// per-entry valid bits, so there is no clearing pass.
module inactivity_sleep_and_stopwatch_ctrl_core #(
    parameter int WINDOW_DEPTH = isc_pkg::ISC_WINDOW_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: accel_x[12:0], second_of_minute[18:13], minute_of_hour[24:19]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [isc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: action[1:0]
    input  logic [1:0]                    s_tuser,
    // m_tdata: stopwatch_running[0], stopwatch_hours[5:1], stopwatch_minutes[11:6],
    //          stopwatch_seconds[17:12], weather_request[18]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [isc_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: event_res[2:0]
    output logic [isc_pkg::EV_W-1:0]      m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import isc_pkg::*;

    logic signed [X_W-1:0] tilt_reg;
    logic [X_W-1:0]        tol_reg;
    logic                  cfg_wr;
    ctrl_t                 ctrl;
    stat_t                 stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_reg <= ISC_TILT_RESET;
            tol_reg  <= ISC_TOL_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TILT: tilt_reg <= $signed(pwdata[X_W-1:0]);
                REG_TOL:  tol_reg  <= pwdata[X_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TILT: prdata = {{(32-X_W){tilt_reg[X_W-1]}}, tilt_reg};
            REG_TOL:  prdata = {{(32-X_W){1'b0}}, tol_reg};
            default:  prdata = '0;
        endcase
    end

    isc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    isc_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .tilt     (tilt_reg),
        .tol      (tol_reg)
    );

    // one item at a time: the sequencer leaves its idle step after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // reciprocal split of the counter stays in range
    a_hms_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:1] <= 5'd18) && (m_tdata[11:6] < 6'd60) &&
                     (m_tdata[17:12] < 6'd60))
        else $error("stopwatch split out of range");

    // only refreshed ticks carry time and weather fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != EV_REFRESHED) |-> (m_tdata[18:1] == '0))
        else $error("time fields set on a non-refresh result");

endmodule

/* bench/isc_status_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isc_status_checker
// Passive checker for the inactivity sleep and stopwatch controller. It
// follows register writes, runs its own copy of the controller state on
// every item transfer, and compares each status transfer field by field
// with the oldest predicted status.
// ----------------------------------------------------------------------------
module isc_status_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // s_tdata: accel_x[12:0], second_of_minute[18:13], minute_of_hour[24:19]
    input  logic [isc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: action[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: stopwatch_running[0], stopwatch_hours[5:1], stopwatch_minutes[11:6],
    //          stopwatch_seconds[17:12], weather_request[18]
    input  logic [isc_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: event_res[2:0]
    input  logic [isc_pkg::EV_W-1:0]      m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            awaiting
);
    import isc_pkg::*;

    typedef struct packed {
        logic [EV_W-1:0]    event_code;
        logic               running;
        logic [HOURS_W-1:0] hours;
        logic [CLK_W-1:0]   minutes;
        logic [CLK_W-1:0]   seconds;
        logic               weather;
    } status_t;

    status_t               awaited_status[$];
    status_t               seen;
    status_t               want;
    status_t               next_status;

    logic signed [X_W-1:0] tilt_level;
    logic [X_W-1:0]        still_tol;
    logic                  asleep;
    logic                  sw_running;
    logic                  refresh_due;
    logic                  batch_armed;
    logic [ELAPSED_W-1:0]  elapsed;
    logic signed [X_W-1:0] motion_log [ISC_WINDOW_DEPTH];
    int                    log_slot;

    task automatic clear_controller();
        tilt_level  = ISC_TILT_RESET;
        still_tol   = ISC_TOL_RESET;
        asleep      = 1'b0;
        sw_running  = 1'b0;
        refresh_due = 1'b1;
        batch_armed = 1'b0;
        elapsed     = '0;
        for (int i = 0; i < ISC_WINDOW_DEPTH; i++)
            motion_log[i] = '0;
        motion_log[1] = ISC_WIN_INIT;
        log_slot    = 0;
        awaited_status.delete();
        awaiting    = 0;
        mismatches  = 0;
    endtask

    function automatic logic window_is_quiet();
        int lo;
        int hi;
        lo = motion_log[0];
        hi = motion_log[0];
        for (int i = 1; i < ISC_WINDOW_DEPTH; i++)
        begin
            if (motion_log[i] < lo) lo = motion_log[i];
            if (motion_log[i] > hi) hi = motion_log[i];
        end
        return (hi - lo) < int'(still_tol);
    endfunction

    task automatic advance_controller(input logic [1:0] action,
                                      input logic signed [X_W-1:0] x,
                                      input logic [CLK_W-1:0] sec,
                                      input logic [CLK_W-1:0] mins,
                                      output status_t r);
        r = '0;
        r.event_code = EV_NONE;
        case (action)
            ACT_TICK:
            begin
                if (asleep || (!refresh_due && !sw_running && sec != 0))
                    r.event_code = EV_IGNORED;
                else
                begin
                    refresh_due  = 1'b0;
                    r.event_code = EV_REFRESHED;
                    if (sec == 0)
                    begin
                        if (log_slot >= ISC_WINDOW_DEPTH) log_slot = 0;
                        motion_log[log_slot] = x;
                        log_slot++;
                        if (window_is_quiet())
                        begin
                            asleep       = 1'b1;
                            r.event_code = EV_SLEPT;
                        end
                    end
                    if (r.event_code == EV_REFRESHED)
                    begin
                        // display shows the count before this tick adds to it
                        if (sw_running)
                        begin
                            r.hours   = HOURS_W'(elapsed / ISC_SEC_PER_HOUR);
                            r.minutes = CLK_W'((elapsed % ISC_SEC_PER_HOUR) / ISC_SEC_PER_MIN);
                            r.seconds = CLK_W'(elapsed % ISC_SEC_PER_MIN);
                            elapsed   = elapsed + 1'b1;
                        end
                        else
                            elapsed = '0;
                        r.weather = (mins == 0) && (sec == 0);
                    end
                end
            end
            ACT_TAP:
            begin
                if (asleep)
                begin
                    asleep       = 1'b0;
                    refresh_due  = 1'b1;
                    r.event_code = EV_WOKE;
                end
                else
                begin
                    batch_armed  = 1'b1;
                    r.event_code = EV_ARMED;
                end
            end
            ACT_BATCH:
            begin
                if (batch_armed)
                begin
                    batch_armed = 1'b0;
                    if (x < tilt_level)
                    begin
                        if (sw_running)
                        begin
                            sw_running   = 1'b0;
                            refresh_due  = 1'b1;
                            r.event_code = EV_SW_OFF;
                        end
                        else
                        begin
                            sw_running   = 1'b1;
                            r.event_code = EV_SW_ON;
                        end
                    end
                end
            end
            default:
                refresh_due = 1'b1;
        endcase
        r.running = sw_running;
    endtask

    task automatic report_mismatch(input string what, input int got, input int wanted);
        if (mismatches < 40)
            $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, wanted);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_controller();
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_TILT)
                        tilt_level = pwdata[X_W-1:0];
                    else
                        still_tol = pwdata[X_W-1:0];
                end
                else if (paddr[2] == REG_TILT)
                begin
                    if (prdata[X_W-1:0] != tilt_level)
                        report_mismatch("tilt_trip_level read", prdata[X_W-1:0],
                                        tilt_level[X_W-1:0]);
                end
                else if (prdata[X_W-1:0] != still_tol)
                    report_mismatch("stillness_tolerance read", prdata[X_W-1:0], still_tol);
            end

            if (m_tvalid && m_tready)
            begin
                seen.event_code = m_tuser;
                seen.running    = m_tdata[0];
                seen.hours      = m_tdata[5:1];
                seen.minutes    = m_tdata[11:6];
                seen.seconds    = m_tdata[17:12];
                seen.weather    = m_tdata[18];
                if (awaited_status.size() == 0)
                    report_mismatch("status with nothing awaited, event_res", seen.event_code, 0);
                else
                begin
                    want = awaited_status.pop_front();
                    if (seen.event_code != want.event_code)
                        report_mismatch("event_res", seen.event_code, want.event_code);
                    if (seen.running != want.running)
                        report_mismatch("stopwatch_running", seen.running, want.running);
                    if (seen.hours != want.hours)
                        report_mismatch("stopwatch_hours", seen.hours, want.hours);
                    if (seen.minutes != want.minutes)
                        report_mismatch("stopwatch_minutes", seen.minutes, want.minutes);
                    if (seen.seconds != want.seconds)
                        report_mismatch("stopwatch_seconds", seen.seconds, want.seconds);
                    if (seen.weather != want.weather)
                        report_mismatch("weather_request", seen.weather, want.weather);
                end
            end

            if (s_tvalid && s_tready)
            begin
                advance_controller(s_tuser, s_tdata[X_W-1:0], s_tdata[X_W +: CLK_W],
                                   s_tdata[X_W+CLK_W +: CLK_W], next_status);
                awaited_status.push_back(next_status);
            end
            awaiting = awaited_status.size();
        end
    end

endmodule

/* bench/inactivity_sleep_and_stopwatch_ctrl_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inactivity_sleep_and_stopwatch_ctrl_core_tb
// Drives taps, batches, refreshes and wall clock ticks into the controller,
// reprograms the tilt and stillness registers between segments, and throttles
// both stream sides. The checker predicts and compares every status transfer.
// ----------------------------------------------------------------------------
module inactivity_sleep_and_stopwatch_ctrl_core_tb;
    import isc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int SEGMENT_ITEMS = 171;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: accel_x[12:0], second_of_minute[18:13], minute_of_hour[24:19]
    logic [S_TDATA_W-1:0]  s_tdata;
    // s_tuser: action[1:0]
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: stopwatch_running[0], stopwatch_hours[5:1], stopwatch_minutes[11:6],
    //          stopwatch_seconds[17:12], weather_request[18]
    logic [M_TDATA_W-1:0]  m_tdata;
    // m_tuser: event_res[2:0]
    logic [EV_W-1:0]       m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    mismatches;
    int                    awaiting;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    bit                    hold_request = 1'b0;
    int                    cycle_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    inactivity_sleep_and_stopwatch_ctrl_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    isc_status_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // status side: random back-pressure plus an occasional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[inactivity_sleep_and_stopwatch_ctrl_core] ERROR");
        $finish;
    end

    function automatic int any_x();
        return $urandom_range(0, 8191) - 4096;
    endfunction

    task automatic offer_item(input logic [1:0] action, input int x, input int sec, input int mins);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[X_W-1:0]               = X_W'(x);
        word[X_W +: CLK_W]          = CLK_W'(sec);
        word[X_W+CLK_W +: CLK_W]    = CLK_W'(mins);
        @(negedge clk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering until every predicted status has been seen
    task automatic pause_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write, then read back through the access phase
    task automatic program_register(input logic idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_segment(input int tilt, input int tol, input int tx_pct, input int rx_pct,
                               input int jitter, input bit long_hold, input bit mid_drain);
        int sent;
        int pick;
        int base;
        int x;
        int sec;
        int mins;
        sent = 0;
        base = $urandom_range(0, 6000) - 3000;
        pause_until_drained();
        program_register(REG_TILT, tilt);
        program_register(REG_TOL, tol);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < SEGMENT_ITEMS)
        begin
            if (long_hold && sent >= 60)
            begin
                hold_request = 1'b1;
                long_hold    = 1'b0;
            end
            if (mid_drain && sent >= 90)
            begin
                pause_until_drained();
                mid_drain = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                sec  = ($urandom_range(99) < 40) ? 0 : $urandom_range(63);
                mins = ($urandom_range(99) < 25) ? 0 : $urandom_range(63);
                // a quiet segment keeps most samples near one level so sleep can happen
                if (jitter > 0 && $urandom_range(99) < 85)
                    x = base + $urandom_range(0, 2 * jitter) - jitter;
                else
                    x = any_x();
                offer_item(ACT_TICK, x, sec, mins);
            end
            else if (pick < 58)
                offer_item(ACT_TAP, any_x(), $urandom_range(63), $urandom_range(63));
            else if (pick < 70)
            begin
                // arm, then a batch that trips the tilt level
                offer_item(ACT_TAP, any_x(), $urandom_range(63), $urandom_range(63));
                offer_item(ACT_BATCH, $urandom_range(0, tilt + 4095) - 4096,
                           $urandom_range(63), $urandom_range(63));
                sent++;
            end
            else if (pick < 88)
                offer_item(ACT_BATCH, any_x(), $urandom_range(63), $urandom_range(63));
            else
                offer_item(ACT_REFRESH, any_x(), $urandom_range(63), $urandom_range(63));
            sent++;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: tilt -800, tolerance 50
        offer_item(ACT_REFRESH, 0, 0, 0);
        offer_item(ACT_TICK, 0, 5, 3);
        offer_item(ACT_TICK, 0, 7, 3);
        offer_item(ACT_TICK, 0, 63, 63);
        offer_item(ACT_BATCH, -4096, 0, 0);
        offer_item(ACT_TAP, 0, 0, 0);
        offer_item(ACT_BATCH, 4095, 0, 0);
        offer_item(ACT_TAP, 0, 0, 0);
        offer_item(ACT_BATCH, -4096, 0, 0);
        offer_item(ACT_TICK, -1, 61, 0);
        offer_item(ACT_TICK, 100, 0, 0);
        offer_item(ACT_TICK, -200, 0, 60);
        offer_item(ACT_TAP, 0, 0, 0);
        offer_item(ACT_BATCH, -801, 0, 0);
        offer_item(ACT_TICK, 0, 9, 59);

        // wide tolerance: next minute tick sleeps, armed batch still toggles
        pause_until_drained();
        program_register(REG_TILT, -4000);
        program_register(REG_TOL, 8000);
        offer_item(ACT_TAP, 0, 0, 0);
        offer_item(ACT_TICK, 50, 0, 17);
        offer_item(ACT_TICK, 0, 0, 0);
        offer_item(ACT_BATCH, -4096, 0, 0);
        offer_item(ACT_TICK, 0, 30, 0);
        offer_item(ACT_TAP, 0, 0, 0);
        offer_item(ACT_TICK, 0, 12, 0);
        offer_item(ACT_REFRESH, 0, 0, 0);

        run_segment(4000, 0, 19, 83, 0, 1'b1, 1'b0);
        run_segment(-800, 300, 19, 83, 60, 1'b0, 1'b0);
        run_segment(-4000, 8000, 83, 19, 0, 1'b0, 1'b1);
        run_segment(0, 1000, 83, 19, 300, 1'b0, 1'b0);
        run_segment(123, 8191, 0, 0, 0, 1'b0, 1'b0);
        run_segment(-800, 50, 0, 0, 10, 1'b0, 1'b0);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[inactivity_sleep_and_stopwatch_ctrl_core] OK");
        else
            $display("[inactivity_sleep_and_stopwatch_ctrl_core] ERROR");
        $finish;
    end

endmodule
